// ===== sv/fully_assoc_fifo_cache_tags_unit_macros.svh =====
// assertion helpers used by the tags unit rtl
`ifndef FULLY_ASSOC_FIFO_CACHE_TAGS_UNIT_MACROS_SVH
`define FULLY_ASSOC_FIFO_CACHE_TAGS_UNIT_MACROS_SVH

// condition holds on every clock out of reset
`define FAFC_AST_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fafc invariant violated");

// antecedent implies consequent on the next clock
`define FAFC_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fafc sequence violated");

`endif

// ===== sv/fafc_pkg.sv =====
`default_nettype none
package fafc_pkg;

    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned OFFSET_W  = 5;
    localparam int unsigned LCOUNT_W  = 7;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 8'd1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd5;
    localparam logic [LCOUNT_W-1:0] LCOUNT_RESET = 7'd64;

    // per-line control from the replacement logic
    typedef struct packed {
        logic clear;
        logic evict;
        logic fill;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== sv/fafc_cell.sv =====
`default_nettype none
module fafc_cell #(
    parameter int unsigned TAG_W = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire fafc_pkg::t_cell_ctrl i_ctrl,
    input  wire [TAG_W-1:0]           i_tag,
    input  wire                       i_hit,
    output logic                      o_hit
);

    logic             r_valid;
    logic [TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.fill) begin
            r_valid <= 1'b1;
        end else if (i_ctrl.evict) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill) begin
            r_tag <= i_tag;
        end
    end

    // match flag ripples down the row
    assign o_hit = i_hit | (r_valid && (r_tag == i_tag));

endmodule
`default_nettype wire

// ===== sv/fully_assoc_fifo_cache_tags_unit.sv =====
// pipeline: an accepted address is registered into the lookup stage, and its result word into the output register
// throughput: one address per cycle while the receiver takes words; all line cells
// compare in the cycle after accept and the fifo pointer and cells update on a miss as the lookup stage finishes
// a stalled result holds the next address in the lookup stage and the input waits
// reset: synchronous active low; clears line valid bits, fifo pointer, occupancy,
// counters and pipeline valids; registers return to offset 5 and 64 lines
`default_nettype none
`include "fully_assoc_fifo_cache_tags_unit_macros.svh"
module fully_assoc_fifo_cache_tags_unit #(
    parameter int unsigned MAX_LINES  = 64,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // cfg: index and data of one register write
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [fafc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [fafc_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    // slave tdata: address
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire [((ADDR_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    // master tdata: hit_total, miss_total
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    output logic [2*fafc_pkg::COUNT_W-1:0]        o_m_tdata,
    // master tuser: hit
    output logic                                  o_m_tuser
);

    localparam int unsigned PW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int unsigned OW = $clog2(MAX_LINES + 1);
    localparam int unsigned SW = OW + 1;
    localparam int unsigned CW = fafc_pkg::COUNT_W;

    logic [fafc_pkg::OFFSET_W-1:0] r_offset;
    logic [fafc_pkg::LCOUNT_W-1:0] r_lcount;

    logic                  r_busy;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic [PW-1:0]         r_oldest;
    logic [OW-1:0]         r_occ;
    logic [CW-1:0]         r_hit_cnt;
    logic [CW-1:0]         r_miss_cnt;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [CW-1:0]         r_out_hits;
    logic [CW-1:0]         r_out_misses;

    logic                  cfg_wr;
    logic                  cfg_clear;
    logic                  s_acc;
    logic                  done;
    logic                  hit;
    logic                  miss;
    logic                  full;
    logic [OW-1:0]         limit;
    logic [SW-1:0]         slot_sum;
    logic [PW-1:0]         slot;
    logic [PW-1:0]         oldest_inc;
    logic [CW-1:0]         n_hit_cnt;
    logic [CW-1:0]         n_miss_cnt;
    logic [MAX_LINES:0]    hit_chain;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    // only a write to a known register empties the lines
    assign cfg_clear   = cfg_wr && (i_cfg_index inside {fafc_pkg::REG_OFFSET_BITS,
                                                        fafc_pkg::REG_LINE_COUNT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= fafc_pkg::OFFSET_RESET;
            r_lcount <= fafc_pkg::LCOUNT_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                fafc_pkg::REG_OFFSET_BITS: r_offset <= i_cfg_data[fafc_pkg::OFFSET_W-1:0];
                fafc_pkg::REG_LINE_COUNT:  r_lcount <= i_cfg_data[fafc_pkg::LCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // lookup stage finishes when the output register can take its word
    assign done       = r_busy && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_busy || done;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // zero lines counts as one, above the row saturates
    always_comb begin
        if (r_lcount == '0) begin
            limit = OW'(1);
        end else if (32'(r_lcount) > MAX_LINES) begin
            limit = OW'(MAX_LINES);
        end else begin
            limit = OW'(r_lcount);
        end
    end

    assign hit  = hit_chain[MAX_LINES];
    assign miss = done && !hit;
    assign full = (r_occ >= limit);

    // new line goes after the newest: the oldest's place plus occupancy, mod the row
    assign slot_sum = SW'(r_oldest) + SW'(r_occ);
    assign slot     = (slot_sum >= SW'(MAX_LINES)) ? PW'(slot_sum - SW'(MAX_LINES))
                                                   : PW'(slot_sum);
    assign oldest_inc = (32'(r_oldest) + 32'd1 >= MAX_LINES) ? '0 : PW'(r_oldest + 1'b1);

    assign hit_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_LINES; g++) begin : g_cell
            fafc_pkg::t_cell_ctrl ctrl;
            always_comb begin
                ctrl.clear = cfg_clear;
                ctrl.fill  = miss && (slot == PW'(g));
                ctrl.evict = miss && full && (r_oldest == PW'(g));
            end
            fafc_cell #(
                .TAG_W (ADDR_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (ctrl),
                .i_tag   (r_tag),
                .i_hit   (hit_chain[g]),
                .o_hit   (hit_chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (done && hit && (r_hit_cnt != '1)) begin
            n_hit_cnt = r_hit_cnt + 1'b1;
        end
        if (miss && (r_miss_cnt != '1)) begin
            n_miss_cnt = r_miss_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_oldest    <= '0;
            r_occ       <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (cfg_clear) begin
                r_oldest <= '0;
                r_occ    <= '0;
            end else if (miss) begin
                if (full) begin
                    r_oldest <= oldest_inc;
                end else begin
                    r_occ <= r_occ + 1'b1;
                end
            end
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_tag <= i_s_tdata[ADDR_WIDTH-1:0] >> r_offset;
        end
        if (done) begin
            r_out_hit    <= hit;
            r_out_hits   <= n_hit_cnt;
            r_out_misses <= n_miss_cnt;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = {r_out_misses, r_out_hits};

    `FAFC_AST_ALWAYS(a_occ_le_limit, i_clk, i_rst_n, r_occ <= limit || r_occ == '0)
    `FAFC_AST_ALWAYS(a_oldest_in_row, i_clk, i_rst_n, 32'(r_oldest) < MAX_LINES)
    `FAFC_AST_NEXT(a_done_shows_word, i_clk, i_rst_n, done, o_m_tvalid)
    `FAFC_AST_NEXT(a_miss_counted, i_clk, i_rst_n, miss && !cfg_wr,
                   r_miss_cnt == $past(r_miss_cnt) + 1'b1 || r_miss_cnt == '1)

endmodule
`default_nettype wire
